FILE: rtl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge, disabled while reset is active.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is active.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/cec_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package cec_pkg;
	localparam logic [1:0] ACT_PASS   = 2'd0;
	localparam logic [1:0] ACT_HSV    = 2'd1;
	localparam logic [1:0] ACT_INVERT = 2'd2;

	localparam logic REG_NEAR = 1'b0;
	localparam logic REG_FAR  = 1'b1;

	localparam int THR_W = 18;
	localparam logic [THR_W-1:0] NEAR_RESET = 18'd10000;
	localparam logic [THR_W-1:0] FAR_RESET  = 18'd50000;
endpackage
`default_nettype wire

FILE: rtl/cec_divu.sv
`timescale 1ns / 1ps
`default_nettype none
// Exact floor(num * 2^F / den) for num <= den, den in 1..255, as a
// pipelined restoring divider: F+1 quotient bits, six bits per stage.
module cec_divu
	import cec_pkg::*;
#(
	parameter int F = 16,
	parameter int TAGW = 8
) (
	input  wire logic            clk,
	input  wire logic            en,
	input  wire logic [7:0]      num,
	input  wire logic [7:0]      den,
	input  wire logic [TAGW-1:0] tag_in,
	output logic      [F:0]      quo,
	output logic      [TAGW-1:0] tag_out
);
	localparam int NB = F + 1;
	localparam int PER = 6;
	localparam int NS = (NB + PER - 1) / PER;

	logic [8:0]      rem_q [NS];
	logic [7:0]      den_q [NS];
	logic [NB-1:0]   quo_q [NS];
	logic [TAGW-1:0] tag_q [NS];

	logic [8:0]    r_in [NS];
	logic [7:0]    d_in [NS];
	logic [NB-1:0] q_in [NS];
	logic [8:0]    rem_d [NS];
	logic [NB-1:0] quo_d [NS];

	always_comb begin
		logic [8:0]    r;
		logic [NB-1:0] qv;
		r_in[0] = {1'b0, num};
		d_in[0] = den;
		q_in[0] = '0;
		for (int s = 1; s < NS; s++) begin
			r_in[s] = rem_q[s-1];
			d_in[s] = den_q[s-1];
			q_in[s] = quo_q[s-1];
		end
		for (int s = 0; s < NS; s++) begin
			r = r_in[s];
			qv = q_in[s];
			for (int k = 0; k < PER; k++) begin
				if (s * PER + k < NB) begin
					if (s * PER + k > 0) begin
						r = {r[7:0], 1'b0};
					end
					qv = {qv[NB-2:0], 1'b0};
					if (r >= {1'b0, d_in[s]}) begin
						r = r - {1'b0, d_in[s]};
						qv[0] = 1'b1;
					end
				end
			end
			rem_d[s] = r;
			quo_d[s] = qv;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int s = 0; s < NS; s++) begin
				rem_q[s] <= rem_d[s];
				quo_q[s] <= quo_d[s];
				den_q[s] <= d_in[s];
			end
			tag_q[0] <= tag_in;
			for (int s = 1; s < NS; s++) begin
				tag_q[s] <= tag_q[s-1];
			end
		end
	end

	assign quo = quo_q[NS-1];
	assign tag_out = tag_q[NS-1];
endmodule
`default_nettype wire

FILE: rtl/contrast_enforce_color.sv
// contrast_enforce_color
// Input channel: in_valid/in_ready carry one foreground and background colour
// pair per request. Output channel: out_valid/out_ready carry the adjusted
// foreground and an action code per request, one result for each request.
// Configuration: cfg_we writes near (index 0) or far (index 1) threshold;
// other indexes are ignored. Write only while the block holds no request.
// Throughput is one request per cycle while the receiver is not stalling.
// From acceptance to the output the pipeline runs through two front stages,
// the saturation and hue dividers, then two product stages and the output
// register. Its depth is set by the two restoring dividers running in
// parallel at six quotient bits per stage.
// When the receiver stalls, the whole pipeline holds and in_ready falls while
// the last stage holds a result that is not taken; nothing is lost or repeated.
// Reset clears all valid bits and loads the thresholds with 10000 and 50000.
`timescale 1ns / 1ps
`default_nettype none
module contrast_enforce_color
	import cec_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [0:0]       cfg_index,
	input  wire logic [THR_W-1:0] cfg_data,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic [7:0]       fore_red,
	input  wire logic [7:0]       fore_green,
	input  wire logic [7:0]       fore_blue,
	input  wire logic [7:0]       back_red,
	input  wire logic [7:0]       back_green,
	input  wire logic [7:0]       back_blue,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic      [7:0]       out_red,
	output logic      [7:0]       out_green,
	output logic      [7:0]       out_blue,
	output logic      [1:0]       action
);
	localparam int F = FRAC_BITS;
	localparam int NS = (F + 1 + 5) / 6;
	localparam int LAT = 2 + NS + 3;

	logic [THR_W-1:0] near_q, far_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			near_q <= NEAR_RESET;
			far_q  <= FAR_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NEAR: near_q <= cfg_data;
				REG_FAR:  far_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// One global enable: the pipeline advances unless the last stage holds
	// a result that is not taken.
	logic en;
	logic [LAT-1:0] vld_q;
	assign en = !vld_q[LAT-1] || out_ready;
	assign in_ready = en;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-2:0], in_valid};
		end
	end
	assign out_valid = vld_q[LAT-1];

	// Stage 1: differences squared, maxima and minima.
	logic [7:0]  fr_s1, fg_s1, fb_s1, mx_s1, mn_s1, bmx_s1;
	logic [15:0] sr_s1, sg_s1, sb_s1;
	logic [8:0]  dr, dg, db;
	logic [7:0]  adr, adg, adb, mx0, mn0, bm0;
	always_comb begin
		dr = {1'b0, fore_red} - {1'b0, back_red};
		dg = {1'b0, fore_green} - {1'b0, back_green};
		db = {1'b0, fore_blue} - {1'b0, back_blue};
		adr = dr[8] ? 8'(-dr) : dr[7:0];
		adg = dg[8] ? 8'(-dg) : dg[7:0];
		adb = db[8] ? 8'(-db) : db[7:0];
		mx0 = fore_red > fore_green ? fore_red : fore_green;
		mx0 = mx0 > fore_blue ? mx0 : fore_blue;
		mn0 = fore_red < fore_green ? fore_red : fore_green;
		mn0 = mn0 < fore_blue ? mn0 : fore_blue;
		bm0 = back_red > back_green ? back_red : back_green;
		bm0 = bm0 > back_blue ? bm0 : back_blue;
	end
	always_ff @(posedge clk) begin
		if (en) begin
			fr_s1 <= fore_red; fg_s1 <= fore_green; fb_s1 <= fore_blue;
			sr_s1 <= adr * adr; sg_s1 <= adg * adg; sb_s1 <= adb * adb;
			mx_s1 <= mx0; mn_s1 <= mn0; bmx_s1 <= bm0;
		end
	end

	// Stage 2: distance, decision, hue numerator and sector.
	logic [17:0] sq_dist;
	logic [1:0]  act2;
	logic [7:0]  hnum;
	logic [2:0]  sec2;
	logic        neg2;
	assign sq_dist = 18'(sr_s1) + 18'(sg_s1) + 18'(sb_s1);
	always_comb begin
		if (sq_dist > far_q) begin
			act2 = ACT_PASS;
		end else if (sq_dist > near_q) begin
			act2 = ACT_HSV;
		end else begin
			act2 = ACT_INVERT;
		end
		neg2 = 1'b0;
		if (fr_s1 == mx_s1) begin
			sec2 = 3'd0;
			if (fg_s1 >= fb_s1) begin
				hnum = fg_s1 - fb_s1;
			end else begin
				hnum = fb_s1 - fg_s1; neg2 = 1'b1; sec2 = 3'd6;
			end
		end else if (fg_s1 == mx_s1) begin
			sec2 = 3'd2;
			if (fb_s1 >= fr_s1) begin
				hnum = fb_s1 - fr_s1;
			end else begin
				hnum = fr_s1 - fb_s1; neg2 = 1'b1;
			end
		end else begin
			sec2 = 3'd4;
			if (fr_s1 >= fg_s1) begin
				hnum = fr_s1 - fg_s1;
			end else begin
				hnum = fg_s1 - fr_s1; neg2 = 1'b1;
			end
		end
	end
	logic [7:0] fr_s2, fg_s2, fb_s2, mx_s2, dl_s2, hn_s2;
	logic [8:0] vn_s2;
	logic [1:0] act_s2;
	logic [2:0] sec_s2;
	logic       neg_s2;
	always_ff @(posedge clk) begin
		if (en) begin
			fr_s2 <= fr_s1; fg_s2 <= fg_s1; fb_s2 <= fb_s1;
			mx_s2 <= mx_s1; dl_s2 <= mx_s1 - mn_s1; hn_s2 <= hnum;
			vn_s2 <= (mx_s1 > bmx_s1) ? 9'd255 + 9'(mx_s1) : 9'(mx_s1);
			act_s2 <= act2; sec_s2 <= sec2; neg_s2 <= neg2;
		end
	end

	// Stage 3: v = floor(vn * ONE / 510) = floor(vn * 2^(F-1) / 255);
	// vn/255 via reciprocal multiply and one correction.
	logic [F+9:0] vprod;
	logic [F:0]   vq;
	logic [F+9:0] vrem;
	always_comb begin
		vprod = (F+10)'(vn_s2) << (F - 1);
		vq = (F+1)'(((2*F+20)'(vprod) * (2*F+20)'(32'd16843009)) >> 32);
		vrem = vprod - (F+10)'(vq) * (F+10)'(255);
		if (vrem >= (F+10)'(255)) begin
			vq = vq + 1'b1;
		end
	end
	logic [F:0] v_s3;
	always_ff @(posedge clk) begin
		if (en) begin
			v_s3 <= vq;
		end
	end

	// Dividers: s = dl*ONE/mx and t = hnum*ONE/dl. Side data rides as tag.
	localparam int SW = 24 + 2 + 3 + 1;
	logic [SW-1:0] tag_in, tag_o;
	logic [F:0]    s_q, t_q;
	logic [7:0]    dl_t;
	logic [7:0]    dden;
	assign tag_in = {fr_s2, fg_s2, fb_s2, act_s2, sec_s2, neg_s2};
	assign dden = (dl_s2 == 8'd0) ? 8'd1 : dl_s2;
	cec_divu #(.F(F), .TAGW(SW)) u_sdiv (
		.clk(clk), .en(en),
		.num(dl_s2), .den((mx_s2 == 8'd0) ? 8'd1 : mx_s2),
		.tag_in(tag_in), .quo(s_q), .tag_out(tag_o)
	);
	cec_divu #(.F(F), .TAGW(8)) u_tdiv (
		.clk(clk), .en(en),
		.num(hn_s2), .den(dden), .tag_in(dl_s2), .quo(t_q), .tag_out(dl_t)
	);
	// v delayed to meet the divider outputs (v is one stage later than s2).
	logic [F:0] vd_q [NS-1];
	always_ff @(posedge clk) begin
		if (en) begin
			vd_q[0] <= v_s3;
			for (int i = 1; i < NS - 1; i++) begin
				vd_q[i] <= vd_q[i-1];
			end
		end
	end
	// Tag and quotients leave the dividers NS stages after stage 2; v_s3 is
	// one stage after stage 2, so vd_q[NS-2] aligns (NS >= 2).
	logic [F:0] v_al;
	assign v_al = vd_q[NS-2];

	// Stage A: hue, sector, fraction, s*f and s*(ONE-f).
	logic [7:0] frA, fgA, fbA, dlA;
	logic [1:0] actA;
	logic [2:0] secA;
	logic       negA;
	assign {frA, fgA, fbA, actA, secA, negA} = tag_o;
	assign dlA = dl_t;
	logic [F+3:0] h6;
	logic [2:0]   hi;
	logic [F-1:0] hf;
	always_comb begin
		if (negA) begin
			h6 = ((F+4)'(secA) << F) - (F+4)'(t_q);
		end else begin
			h6 = ((F+4)'(secA) << F) + (F+4)'(t_q);
		end
		if (h6 >= ((F+4)'(6) << F)) begin
			h6 = '0;
		end
		hi = h6[F+2:F];
		hf = h6[F-1:0];
	end
	logic [F:0]   v_sA, s_sA;
	logic [F:0]   sf_sA, sg_sA;
	logic [2:0]   hi_sA;
	logic [7:0]   fr_sA, fg_sA, fb_sA;
	logic [1:0]   act_sA;
	logic         gray_sA;
	logic [2*F:0] sfp, sgp;
	assign sfp = (2*F+1)'(s_q) * (2*F+1)'(hf);
	assign sgp = (2*F+1)'(s_q) * (2*F+1)'(((F+1)'(1) << F) - (F+1)'(hf));
	always_ff @(posedge clk) begin
		if (en) begin
			v_sA <= v_al; s_sA <= s_q; hi_sA <= hi;
			sf_sA <= (F+1)'(sfp >> F); sg_sA <= (F+1)'(sgp >> F);
			fr_sA <= frA; fg_sA <= fgA; fb_sA <= fbA; act_sA <= actA;
			gray_sA <= (dlA == 8'd0);
		end
	end

	// Stage B: A, B, C products.
	logic [F:0]   one_v;
	logic [2*F+1:0] pa, pb, pc;
	assign one_v = (F+1)'(1) << F;
	assign pa = (2*F+2)'(v_sA) * (2*F+2)'(one_v - s_sA);
	assign pb = (2*F+2)'(v_sA) * (2*F+2)'(one_v - sf_sA);
	assign pc = (2*F+2)'(v_sA) * (2*F+2)'(one_v - sg_sA);
	logic [F:0] a_sB, b_sB, c_sB, v_sB;
	logic [2:0] hi_sB;
	logic [7:0] fr_sB, fg_sB, fb_sB;
	logic [1:0] act_sB;
	logic       gray_sB;
	always_ff @(posedge clk) begin
		if (en) begin
			a_sB <= (F+1)'(pa >> F); b_sB <= (F+1)'(pb >> F);
			c_sB <= (F+1)'(pc >> F); v_sB <= v_sA; hi_sB <= hi_sA;
			fr_sB <= fr_sA; fg_sB <= fg_sA; fb_sB <= fb_sA;
			act_sB <= act_sA; gray_sB <= gray_sA;
		end
	end

	// Stage C: sector select, scale to eight bits, final choice.
	logic [F:0] ro, go, bo;
	always_comb begin
		if (gray_sB) begin
			ro = v_sB; go = v_sB; bo = v_sB;
		end else begin
			case (hi_sB)
				3'd0: begin ro = v_sB; go = c_sB; bo = a_sB; end
				3'd1: begin ro = b_sB; go = v_sB; bo = a_sB; end
				3'd2: begin ro = a_sB; go = v_sB; bo = c_sB; end
				3'd3: begin ro = a_sB; go = b_sB; bo = v_sB; end
				3'd4: begin ro = c_sB; go = a_sB; bo = v_sB; end
				default: begin ro = v_sB; go = a_sB; bo = b_sB; end
			endcase
		end
	end
	function automatic logic [7:0] to_chan(input logic [F:0] x);
		logic [F+8:0] p;
		logic [8:0]   c;
		begin
			p = (F+9)'(x) * (F+9)'(255);
			c = 9'(p >> F);
			return (c > 9'd255) ? 8'd255 : c[7:0];
		end
	endfunction
	always_ff @(posedge clk) begin
		if (en) begin
			case (act_sB)
				ACT_PASS: begin
					out_red <= fr_sB; out_green <= fg_sB; out_blue <= fb_sB;
				end
				ACT_HSV: begin
					out_red <= to_chan(ro); out_green <= to_chan(go);
					out_blue <= to_chan(bo);
				end
				default: begin
					out_red <= ~fr_sB; out_green <= ~fg_sB; out_blue <= ~fb_sB;
				end
			endcase
			action <= act_sB;
		end
	end
endmodule
`default_nettype wire

FILE: rtl/cec_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module cec_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [1:0] action
);
	logic stall;
	assign stall = out_valid && !out_ready;

	`ASSERT_IMPL(a_act_range, clk, arst_n, out_valid, action != 2'd3, "bad action code")
	`ASSERT_NEXT(a_out_hold, clk, arst_n, stall, out_valid && $stable(action), "result dropped")
	`ASSERT_IMPL(a_ready_free, clk, arst_n, !out_valid, in_ready, "input blocked when empty")
	`ASSERT_IMPL(a_ready_stall, clk, arst_n, stall, !in_ready, "input taken while stalled")
endmodule
bind contrast_enforce_color cec_checker u_cec_checker (
	.clk(clk), .arst_n(arst_n), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .action(action)
);
`default_nettype wire
